/* hdl/sopf_pkg.sv */
// ----------------------------------------------------------------------------
// sopf_pkg
// Shared types and constants for the stereo one-pole filter and mix block.
// ----------------------------------------------------------------------------
package sopf_pkg;

  localparam int unsigned CHANNELS         = 2;
  localparam int unsigned CH_IDX_BITS      = 1;
  localparam int unsigned CARRY_BITS       = 32;
  localparam int unsigned DEF_SAMPLE_BITS  = 24;
  localparam int unsigned DEF_COEF_BITS    = 18;
  localparam int unsigned CFG_IDX_BITS     = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LPF_ENABLE = 3'd0,
    REG_LPF_A0     = 3'd1,
    REG_LPF_A1     = 3'd2,
    REG_LPF_B1     = 3'd3,
    REG_HPF_ENABLE = 3'd4,
    REG_HPF_A0     = 3'd5,
    REG_HPF_A1     = 3'd6,
    REG_HPF_B1     = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    STG_LPF = 1'b0,
    STG_HPF = 1'b1
  } stage_e;

  typedef enum logic [1:0] {
    MUL_X_A0 = 2'd0,
    MUL_X_A1 = 2'd1,
    MUL_Y_B1 = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic                   capture;    // latch the input frame
    logic                   load_x;     // working sample <= channel sample
    logic                   mul_en;     // register a new product
    mul_sel_e               mul_sel;
    logic                   upd_y;      // y <= sat(rnd + carry)
    logic                   upd_t1;     // t1 <= rnd
    logic                   upd_carry;  // carry <= sat(t1 - rnd), x <= y
    logic                   mix;        // result[ch] <= sat(mix + x)
    logic                   emit;       // move results into output register
    logic [CH_IDX_BITS-1:0] ch;
    stage_e                 stg;
  } cmd_t;

  typedef struct packed {
    logic lpf_en;
    logic hpf_en;
    logic out_free;
  } status_t;

endpackage

/* hdl/sopf_ctrl.sv */
// ----------------------------------------------------------------------------
// sopf_ctrl
// Sequencer: walks each channel through the enabled filter stages, three
// products per stage on the shared multiplier, then the mix add.
// ----------------------------------------------------------------------------
module sopf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sopf_pkg::status_t status_i,
  output sopf_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOADX = 8'b0000_0010,
    ST_MULA0 = 8'b0000_0100,
    ST_YSUM  = 8'b0000_1000,
    ST_T1    = 8'b0001_0000,
    ST_CARRY = 8'b0010_0000,
    ST_MIX   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e                           state_q, state_d;
  logic [sopf_pkg::CH_IDX_BITS-1:0] ch_q, ch_d;
  sopf_pkg::stage_e                 stg_q, stg_d;

  localparam logic [sopf_pkg::CH_IDX_BITS-1:0] LAST_CH =
    sopf_pkg::CH_IDX_BITS'(sopf_pkg::CHANNELS - 1);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    stg_d   = stg_q;
    cmd_o   = '0;
    cmd_o.ch      = ch_q;
    cmd_o.stg     = stg_q;
    cmd_o.mul_sel = sopf_pkg::MUL_X_A0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          ch_d          = '0;
          state_d       = ST_LOADX;
        end
      end
      ST_LOADX: begin
        cmd_o.load_x = 1'b1;
        if (status_i.lpf_en) begin
          stg_d   = sopf_pkg::STG_LPF;
          state_d = ST_MULA0;
        end else if (status_i.hpf_en) begin
          stg_d   = sopf_pkg::STG_HPF;
          state_d = ST_MULA0;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_MULA0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = sopf_pkg::MUL_X_A0;
        state_d       = ST_YSUM;
      end
      ST_YSUM: begin
        cmd_o.upd_y   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = sopf_pkg::MUL_X_A1;
        state_d       = ST_T1;
      end
      ST_T1: begin
        cmd_o.upd_t1  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = sopf_pkg::MUL_Y_B1;
        state_d       = ST_CARRY;
      end
      ST_CARRY: begin
        cmd_o.upd_carry = 1'b1;
        if (stg_q == sopf_pkg::STG_LPF && status_i.hpf_en) begin
          stg_d   = sopf_pkg::STG_HPF;
          state_d = ST_MULA0;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        if (ch_q == LAST_CH) begin
          state_d = ST_EMIT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_LOADX;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      stg_q   <= sopf_pkg::STG_LPF;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      stg_q   <= stg_d;
    end
  end

endmodule

/* hdl/sopf_datapath.sv */
// ----------------------------------------------------------------------------
// sopf_datapath
// Coefficient registers, filter carries, one shared multiplier with rounding
// and saturation, mix adder and the output register.
// ----------------------------------------------------------------------------
module sopf_datapath #(
  parameter int unsigned SAMPLE_BITS = sopf_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = sopf_pkg::DEF_COEF_BITS,
  parameter int unsigned IN_BITS     = 4 * SAMPLE_BITS,
  parameter int unsigned OUT_BITS    = 2 * SAMPLE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sopf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [COEF_BITS-1:0]               cfg_data_i,
  input  logic [IN_BITS-1:0]                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [OUT_BITS-1:0]                out_data_o,
  input  sopf_pkg::cmd_t                     cmd_i,
  output sopf_pkg::status_t                  status_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CB = COEF_BITS;
  localparam int unsigned CRB = sopf_pkg::CARRY_BITS;
  localparam int unsigned P  = SB + CB;          // full product
  localparam int unsigned F  = CB - 2;           // Q2.x fraction bits
  localparam int unsigned R  = P - F;            // rounded product
  localparam int unsigned A  = ((R > CRB) ? R : CRB) + 1;
  localparam int unsigned D  = ((R + 1) > (CRB + 1)) ? (R + 1) : (CRB + 1);
  localparam int unsigned NCH = sopf_pkg::CHANNELS;

  localparam logic [P-1:0]  HALF   = {{(P-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CRB-1:0] C_MAX = {1'b0, {(CRB-1){1'b1}}};
  localparam logic [CRB-1:0] C_MIN = {1'b1, {(CRB-1){1'b0}}};

  // configuration
  logic                 lpf_en_q, hpf_en_q;
  logic signed [CB-1:0] lpf_a0_q, lpf_a1_q, lpf_b1_q;
  logic signed [CB-1:0] hpf_a0_q, hpf_a1_q, hpf_b1_q;

  // state and working registers
  logic signed [CRB-1:0] lp_carry_q [NCH];
  logic signed [CRB-1:0] hp_carry_q [NCH];
  logic signed [SB-1:0]  smp_q [NCH];
  logic signed [SB-1:0]  mix_q [NCH];
  logic signed [SB-1:0]  res_q [NCH];
  logic signed [SB-1:0]  x_q, y_q;
  logic signed [R-1:0]   t1_q;
  logic signed [P-1:0]   prod_q;
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   out_data_q;

  logic signed [SB-1:0]  mul_op;
  logic signed [CB-1:0]  mul_coef;
  logic signed [P-1:0]   prod_d;
  logic signed [P-1:0]   prod_biased;
  logic signed [R-1:0]   rnd;
  logic signed [CRB-1:0] carry_cur;
  logic signed [A-1:0]   ysum;
  logic signed [SB-1:0]  y_sat;
  logic signed [D-1:0]   cdiff;
  logic signed [CRB-1:0] c_sat;
  logic signed [SB:0]    msum;
  logic signed [SB-1:0]  m_sat;
  logic [OUT_BITS-1:0]   out_pack;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpf_en_q <= 1'b0;
      lpf_a0_q <= '0;
      lpf_a1_q <= '0;
      lpf_b1_q <= '0;
      hpf_en_q <= 1'b0;
      hpf_a0_q <= '0;
      hpf_a1_q <= '0;
      hpf_b1_q <= '0;
    end else if (cfg_we_i) begin
      case (sopf_pkg::cfg_reg_e'(cfg_index_i))
        sopf_pkg::REG_LPF_ENABLE: lpf_en_q <= cfg_data_i[0];
        sopf_pkg::REG_LPF_A0:     lpf_a0_q <= cfg_data_i;
        sopf_pkg::REG_LPF_A1:     lpf_a1_q <= cfg_data_i;
        sopf_pkg::REG_LPF_B1:     lpf_b1_q <= cfg_data_i;
        sopf_pkg::REG_HPF_ENABLE: hpf_en_q <= cfg_data_i[0];
        sopf_pkg::REG_HPF_A0:     hpf_a0_q <= cfg_data_i;
        sopf_pkg::REG_HPF_A1:     hpf_a1_q <= cfg_data_i;
        sopf_pkg::REG_HPF_B1:     hpf_b1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_op   = x_q;
    mul_coef = (cmd_i.stg == sopf_pkg::STG_LPF) ? lpf_a0_q : hpf_a0_q;
    case (cmd_i.mul_sel)
      sopf_pkg::MUL_X_A0: begin
        mul_op   = x_q;
        mul_coef = (cmd_i.stg == sopf_pkg::STG_LPF) ? lpf_a0_q : hpf_a0_q;
      end
      sopf_pkg::MUL_X_A1: begin
        mul_op   = x_q;
        mul_coef = (cmd_i.stg == sopf_pkg::STG_LPF) ? lpf_a1_q : hpf_a1_q;
      end
      sopf_pkg::MUL_Y_B1: begin
        mul_op   = y_q;
        mul_coef = (cmd_i.stg == sopf_pkg::STG_LPF) ? lpf_b1_q : hpf_b1_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_op * mul_coef;

  // round half up: add half an LSB, then floor
  assign prod_biased = prod_q + $signed(HALF);
  assign rnd         = prod_biased[P-1:F];

  assign carry_cur = (cmd_i.stg == sopf_pkg::STG_LPF) ? lp_carry_q[cmd_i.ch]
                                                      : hp_carry_q[cmd_i.ch];

  always_comb begin
    ysum = A'(rnd) + A'(carry_cur);
    if ((&ysum[A-1:SB-1]) || !(|ysum[A-1:SB-1])) begin
      y_sat = ysum[SB-1:0];
    end else begin
      y_sat = ysum[A-1] ? S_MIN : S_MAX;
    end

    cdiff = D'(t1_q) - D'(rnd);
    if ((&cdiff[D-1:CRB-1]) || !(|cdiff[D-1:CRB-1])) begin
      c_sat = cdiff[CRB-1:0];
    end else begin
      c_sat = cdiff[D-1] ? C_MIN : C_MAX;
    end

    msum = (SB+1)'(mix_q[cmd_i.ch]) + (SB+1)'(x_q);
    if (msum[SB] == msum[SB-1]) begin
      m_sat = msum[SB-1:0];
    end else begin
      m_sat = msum[SB] ? S_MIN : S_MAX;
    end
  end

  // results packed left channel first, zero padded
  always_comb begin
    out_pack = '0;
    for (int i = 0; i < NCH; i++) begin
      out_pack[i*SB +: SB] = res_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        lp_carry_q[i] <= '0;
        hp_carry_q[i] <= '0;
      end
    end else if (cmd_i.upd_carry) begin
      if (cmd_i.stg == sopf_pkg::STG_LPF) begin
        lp_carry_q[cmd_i.ch] <= c_sat;
      end else begin
        hp_carry_q[cmd_i.ch] <= c_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < NCH; i++) begin
        smp_q[i] <= in_data_i[i*SB +: SB];
        mix_q[i] <= in_data_i[(NCH+i)*SB +: SB];
      end
    end
    if (cmd_i.load_x) begin
      x_q <= smp_q[cmd_i.ch];
    end else if (cmd_i.upd_carry) begin
      x_q <= y_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.upd_y) begin
      y_q <= y_sat;
    end
    if (cmd_i.upd_t1) begin
      t1_q <= rnd;
    end
    if (cmd_i.mix) begin
      res_q[cmd_i.ch] <= m_sat;
    end
    if (cmd_i.emit) begin
      out_data_q <= out_pack;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.lpf_en   = lpf_en_q;
  assign status_o.hpf_en   = hpf_en_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* hdl/stereo_one_pole_filter_mix.sv */
// Frames: a new input frame is taken only after the previous result has moved
//   into the output register; each enabled stage (none, one or both) takes three
//   products per channel on the single shared multiplier that serves both
//   channels and both stages.
// Reset: asynchronous, active low; clears configuration, sequencer state, carries and handshakes.
// ----------------------------------------------------------------------------
// stereo_one_pole_filter_mix
// Stereo low-pass then high-pass first-order IIR, added onto the mix bus.
// ----------------------------------------------------------------------------
module stereo_one_pole_filter_mix #(
  parameter int unsigned SAMPLE_BITS = sopf_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = sopf_pkg::DEF_COEF_BITS,
  localparam int unsigned IN_BITS    = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sopf_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COEF_BITS-1:0]              cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_left, sample_right, mix_in_left, mix_in_right, zero pad
  input  logic [IN_BITS-1:0]                s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mix_out_left, mix_out_right, zero pad
  output logic [OUT_BITS-1:0]               m_axis_tdata
);

  sopf_pkg::cmd_t    cmd;
  sopf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  sopf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sopf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .IN_BITS     (IN_BITS),
    .OUT_BITS    (OUT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
